// ===== hw/rtl/tfm_pkg.sv =====
package tfm_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;

  localparam int TIME_W    = 64;
  localparam int ORIGIN_W  = 63;
  localparam int FC_W      = 13;
  localparam int TOL_W     = 30;
  localparam int IDX_W     = 12;
  localparam int CFG_IDX_W = 3;
  // signed width that holds a timestamp shifted by any origin difference
  localparam int EXT_W     = 66;

  localparam logic [TOL_W-1:0] TOL_RESET = 30'd1000000;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEL_ORIGIN  = 3'd0,
    REG_VID_ORIGIN  = 3'd1,
    REG_RANGE_END   = 3'd2,
    REG_FRAME_COUNT = 3'd3,
    REG_TOLERANCE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  entry_index;
    logic [TIME_W-1:0] entry_time;
    logic [TIME_W-1:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] frame_index;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_QK,
    S_WIN,
    S_CHECK,
    S_RD,
    S_CMP,
    S_HIT1,
    S_HIT2,
    S_DONE
  } tfm_state_t;

  typedef struct packed {
    logic capture;
    logic rd_first;
    logic calc_qk;
    logic calc_win;
    logic init_search;
    logic rd_mid;
    logic rd_lo;
    logic upd_probe;
    logic rd_prev;
    logic take_hit1;
    logic take_hit2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_query;
    logic refuse;
    logic count_zero;
    logic hit1;
    logic lo_zero;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/tfm_ram.sv =====
module tfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tfm_ctrl.sv =====
module tfm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tfm_pkg::status_t status,
  output tfm_pkg::cmd_t    cmd
);

  tfm_pkg::tfm_state_t state_r, state_nxt;

  assign in_ready = (state_r == tfm_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfm_pkg::S_IDLE: begin
        if (in_valid && status.in_query) begin
          state_nxt = tfm_pkg::S_START;
        end
      end
      tfm_pkg::S_START: state_nxt = tfm_pkg::S_QK;
      tfm_pkg::S_QK:    state_nxt = tfm_pkg::S_WIN;
      tfm_pkg::S_WIN:   state_nxt = tfm_pkg::S_CHECK;
      tfm_pkg::S_CHECK: begin
        state_nxt = status.refuse ? tfm_pkg::S_DONE : tfm_pkg::S_RD;
      end
      tfm_pkg::S_RD: begin
        state_nxt = status.count_zero ? tfm_pkg::S_HIT1 : tfm_pkg::S_CMP;
      end
      tfm_pkg::S_CMP:   state_nxt = tfm_pkg::S_RD;
      tfm_pkg::S_HIT1: begin
        priority if (status.hit1) begin
          state_nxt = tfm_pkg::S_DONE;
        end else if (!status.lo_zero) begin
          state_nxt = tfm_pkg::S_HIT2;
        end else begin
          state_nxt = tfm_pkg::S_DONE;
        end
      end
      tfm_pkg::S_HIT2:  state_nxt = tfm_pkg::S_DONE;
      tfm_pkg::S_DONE: begin
        if (status.out_free) begin
          state_nxt = tfm_pkg::S_IDLE;
        end
      end
      default: state_nxt = tfm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      tfm_pkg::S_IDLE:  cmd.capture     = in_valid;
      tfm_pkg::S_START: cmd.rd_first    = 1'b1;
      tfm_pkg::S_QK:    cmd.calc_qk     = 1'b1;
      tfm_pkg::S_WIN:   cmd.calc_win    = 1'b1;
      tfm_pkg::S_CHECK: cmd.init_search = 1'b1;
      tfm_pkg::S_RD: begin
        cmd.rd_lo  = status.count_zero;
        cmd.rd_mid = !status.count_zero;
      end
      tfm_pkg::S_CMP:   cmd.upd_probe   = 1'b1;
      tfm_pkg::S_HIT1: begin
        cmd.take_hit1 = 1'b1;
        cmd.rd_prev   = 1'b1;
      end
      tfm_pkg::S_HIT2:  cmd.take_hit2   = 1'b1;
      tfm_pkg::S_DONE:  cmd.load_out    = status.out_free;
      default: cmd = '0;
    endcase
  end

  // a write item never leaves idle
  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tfm_pkg::S_IDLE && in_valid && !status.in_query) |=>
      (state_r == tfm_pkg::S_IDLE))
    else $error("write item left idle");

  a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tfm_pkg::S_DONE && status.out_free) |=> (state_r == tfm_pkg::S_IDLE))
    else $error("result handed off without returning to idle");

endmodule

// ===== hw/rtl/tfm_dp.sv =====
module tfm_dp #(
  parameter int TABLE_DEPTH = tfm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfm_pkg::TIME_W-1:0]      cfg_data,
  input  tfm_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tfm_pkg::out_item_t              out_data,
  input  tfm_pkg::cmd_t                   cmd,
  output tfm_pkg::status_t                status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam int EW = tfm_pkg::EXT_W;

  // configuration registers
  logic [tfm_pkg::ORIGIN_W-1:0] to_r, vo_r;
  logic [tfm_pkg::TIME_W-1:0]   re_r;
  logic [tfm_pkg::FC_W-1:0]     fc_r;
  logic [tfm_pkg::TOL_W-1:0]    tol_r;

  // offsets derived from the origins, refreshed every cycle
  logic signed [EW-1:0] k_r, tmin_r, tmax_r;

  logic [tfm_pkg::TIME_W-1:0] q_r, t0_r;
  logic signed [EW-1:0]       qk_r, qhi_r, qlo_r;
  logic                       re_ok_r;
  logic [CW-1:0]              n_r, lo_r, count_r;
  logic                       res_found_r;
  logic [AW-1:0]              res_idx_r;
  logic                       out_valid_r;
  tfm_pkg::out_item_t         out_data_r;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tfm_pkg::TIME_W-1:0] ram_rdata;

  logic [AW+tfm_pkg::IDX_W-1:0] widx_ext, ridx_ext;
  logic [31:0]                  fc_ext;
  logic signed [EW-1:0]         rd_t, t0_t, re_t, tol_t;
  logic                         rd_valid, t0_ok, less, hit1, hit2, out_free;
  logic [CW-1:0]                step, mid_full, lo_m1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_r  <= '0;
      vo_r  <= '0;
      re_r  <= '0;
      fc_r  <= '0;
      tol_r <= tfm_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tfm_pkg::REG_TEL_ORIGIN:  to_r  <= cfg_data[tfm_pkg::ORIGIN_W-1:0];
        tfm_pkg::REG_VID_ORIGIN:  vo_r  <= cfg_data[tfm_pkg::ORIGIN_W-1:0];
        tfm_pkg::REG_RANGE_END:   re_r  <= cfg_data;
        tfm_pkg::REG_FRAME_COUNT: fc_r  <= cfg_data[tfm_pkg::FC_W-1:0];
        tfm_pkg::REG_TOLERANCE:   tol_r <= cfg_data[tfm_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // mapped = t + k; valid exactly when tmin <= t <= tmax
  always_ff @(posedge clk) begin
    k_r    <= $signed({3'b000, vo_r}) - $signed({3'b000, to_r});
    tmin_r <= $signed({3'b000, to_r}) - $signed({3'b000, vo_r});
    tmax_r <= $signed({3'b000, ~vo_r}) + $signed({3'b000, to_r});
  end

  // table memory
  assign widx_ext  = {{AW{1'b0}}, in_data.entry_index};
  assign ram_waddr = widx_ext[AW-1:0];
  assign ram_we    = cmd.capture && (in_data.kind == tfm_pkg::KIND_WRITE) &&
                     (32'(in_data.entry_index) < 32'(TABLE_DEPTH));

  assign step     = count_r >> 1;
  assign mid_full = lo_r + step;
  assign lo_m1    = lo_r - CW'(1);

  always_comb begin
    priority if (cmd.rd_first) begin
      ram_raddr = '0;
    end else if (cmd.rd_mid) begin
      ram_raddr = mid_full[AW-1:0];
    end else if (cmd.rd_lo) begin
      ram_raddr = (lo_r < n_r) ? lo_r[AW-1:0] : '0;
    end else begin
      ram_raddr = lo_m1[AW-1:0];
    end
  end
  assign ram_re = cmd.rd_first || cmd.rd_mid || cmd.rd_lo || cmd.rd_prev;

  tfm_ram #(
    .WIDTH (tfm_pkg::TIME_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.entry_time),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // compares, all in the shifted query domain
  assign rd_t     = $signed({2'b00, ram_rdata});
  assign t0_t     = $signed({2'b00, t0_r});
  assign re_t     = $signed({2'b00, re_r});
  assign tol_t    = $signed({{(EW-tfm_pkg::TOL_W){1'b0}}, tol_r});
  assign rd_valid = (rd_t >= tmin_r) && (rd_t <= tmax_r);
  assign t0_ok    = (t0_t >= tmin_r) && (t0_t <= tmax_r);
  assign less     = rd_valid && (rd_t < qk_r);
  assign hit1     = (lo_r < n_r) && rd_valid && (rd_t >= qk_r) && (rd_t <= qhi_r);
  assign hit2     = rd_valid && (rd_t <= qk_r) && (rd_t >= qlo_r);
  assign fc_ext   = 32'(fc_r);
  assign out_free = !out_valid_r || out_ready;

  assign status.in_query   = (in_data.kind == tfm_pkg::KIND_QUERY);
  assign status.refuse     = (n_r == '0) || !t0_ok || !re_ok_r || (qk_r >= re_t) ||
                             (t0_t > qhi_r);
  assign status.count_zero = (count_r == '0);
  assign status.hit1       = hit1;
  assign status.lo_zero    = (lo_r == '0);
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_r <= in_data.query_time;
    end
    if (cmd.rd_first) begin
      n_r <= (fc_ext > 32'(TABLE_DEPTH)) ? DEPTH_C : fc_ext[CW-1:0];
    end
    if (cmd.calc_qk) begin
      t0_r    <= ram_rdata;
      qk_r    <= $signed({2'b00, q_r}) - k_r;
      re_ok_r <= (re_t >= tmin_r) && (re_t <= tmax_r);
    end
    if (cmd.calc_win) begin
      qhi_r <= qk_r + tol_t;
      qlo_r <= qk_r - tol_t;
    end
    if (cmd.init_search) begin
      lo_r        <= '0;
      count_r     <= n_r;
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
    end
    if (cmd.upd_probe) begin
      if (less) begin
        lo_r    <= mid_full + CW'(1);
        count_r <= count_r - step - CW'(1);
      end else begin
        count_r <= step;
      end
    end
    if (cmd.take_hit1 && hit1) begin
      res_found_r <= 1'b1;
      res_idx_r   <= lo_r[AW-1:0];
    end
    if (cmd.take_hit2 && hit2) begin
      res_found_r <= 1'b1;
      res_idx_r   <= lo_m1[AW-1:0];
    end
  end

  // output register
  assign ridx_ext = {{tfm_pkg::IDX_W{1'b0}}, res_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.found       <= res_found_r;
      out_data_r.frame_index <= ridx_ext[tfm_pkg::IDX_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_mid |-> (mid_full < n_r))
    else $error("probe beyond frame count");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_probe |-> (({1'b0, lo_r} + {1'b0, count_r}) <= {1'b0, n_r}))
    else $error("search window past frame count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("result overwrote pending item");

  a_prev_exists: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_hit2 |-> (lo_r != '0))
    else $error("predecessor check with no predecessor");

endmodule

// ===== hw/rtl/timestamp_frame_matcher.sv =====
// Matches a video time to a frame of an ascending telemetry timestamp table.
// Write items (kind 0) store one entry if its index is below TABLE_DEPTH and
// produce no result; query items (kind 1) produce exactly one result, and no
// new item is taken until it is loaded into the output register. A query reads
// entry 0, maps the query time, forms and checks the tolerance window, then runs
// a lower-bound binary search with n = min(frame_count, TABLE_DEPTH) and at most
// p = floor(log2(n)) + 1 probes, each a registered read and a compare, and then
// checks the found entry and, if needed, its predecessor; refused queries skip
// the search. Entries must be written before a query reads them. Configuration
// writes are taken in any cycle but must only be issued while no query is in flight.
module timestamp_frame_matcher #(
  parameter int TABLE_DEPTH = tfm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tfm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tfm_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfm_pkg::TIME_W-1:0]    cfg_data
);

  tfm_pkg::cmd_t    cmd;
  tfm_pkg::status_t status;

  tfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tfm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
